/* rtl/vpp_pkg.sv */
// vpp_pkg: shared types and constants of the sound-log command player.
// Used by the channel interfaces and by every module of the block.
`timescale 1ns / 1ps

package vpp_pkg;

   // Wait counter width
   localparam int WAIT_W = 16;

   // Depth of the queue between the decoder and the executor
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Command codes of the stream
   localparam logic [7:0] CMD_SKIP_BYTE  = 8'h4F;
   localparam logic [7:0] CMD_PSG_WRITE  = 8'h50;
   localparam logic [7:0] CMD_WAIT_WORD  = 8'h61;
   localparam logic [7:0] CMD_WAIT_NTSC  = 8'h62;
   localparam logic [7:0] CMD_WAIT_PAL   = 8'h63;
   localparam logic [7:0] CMD_END_DATA   = 8'h66;
   localparam logic [7:0] CMD_SHORT_LO   = 8'h70;
   localparam logic [7:0] CMD_SHORT_HI   = 8'h7F;
   localparam logic [7:0] SHORT_MASK     = 8'h0F;

   // Loaded counts of the fixed waits (one frame minus one)
   localparam logic [WAIT_W-1:0] WAIT_NTSC_LOAD = WAIT_W'(735 - 1);
   localparam logic [WAIT_W-1:0] WAIT_PAL_LOAD  = WAIT_W'(882 - 1);

   // Operation of one input word
   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   // Parser phase
   typedef enum logic [2:0] {
      PH_CMD     = 3'd0,
      PH_SKIP    = 3'd1,
      PH_PSG     = 3'd2,
      PH_WAIT_LO = 3'd3,
      PH_WAIT_HI = 3'd4
   } phase_type;

   // What a byte means when it is read as a command
   typedef enum logic [2:0] {
      KIND_SKIP,
      KIND_PSG,
      KIND_WAIT_WORD,
      KIND_WAIT_LOAD,
      KIND_REWIND,
      KIND_UNKNOWN
   } cmd_kind_type;

   // One decoded word as held in the queue
   typedef struct packed {
      logic              is_tick;
      logic [7:0]        data_byte;
      cmd_kind_type      kind;
      logic [WAIT_W-1:0] load_count;
   } queue_entry_type;

   // One result word
   typedef struct packed {
      logic       psg_write;
      logic [7:0] psg_value;
      logic       byte_ready;
      logic       rewind;
      logic       unknown_command;
   } rsp_payload_type;

endpackage

/* rtl/vpp_if.sv */
// vpp_if: valid/ready channel interfaces for request and response words.
// Depends on vpp_pkg.
`timescale 1ns / 1ps

interface vpp_req_if;
   import vpp_pkg::*;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] data_byte;

   modport source (output valid, output op, output data_byte, input ready);
   modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface vpp_rsp_if;
   import vpp_pkg::*;
   logic       valid;
   logic       ready;
   logic       psg_write;
   logic [7:0] psg_value;
   logic       byte_ready;
   logic       rewind;
   logic       unknown_command;

   modport source (output valid, output psg_write, output psg_value, output byte_ready,
                   output rewind, output unknown_command, input ready);
   modport sink   (input valid, input psg_write, input psg_value, input byte_ready,
                   input rewind, input unknown_command, output ready);
endinterface

/* rtl/vpp_front.sv */
// vpp_front: accepts request words and classifies each byte as a command.
// Depends on vpp_pkg and vpp_if; feeds vpp_queue.
`timescale 1ns / 1ps

module vpp_front (
   vpp_req_if.sink                req_ch,
   output logic                   wr_valid,
   output vpp_pkg::queue_entry_type wr_entry,
   input  logic                   wr_ready
);
   import vpp_pkg::*;

   // Handshake passes straight to the queue
   assign wr_valid     = req_ch.valid;
   assign req_ch.ready = wr_ready;

   // Command decode, independent of parser state
   always_comb begin
      wr_entry            = '0;
      wr_entry.is_tick    = (req_ch.op == OP_TICK);
      wr_entry.data_byte  = req_ch.data_byte;
      wr_entry.kind       = KIND_UNKNOWN;
      wr_entry.load_count = '0;
      if (req_ch.data_byte inside {[CMD_SHORT_LO:CMD_SHORT_HI]}) begin
         wr_entry.kind       = KIND_WAIT_LOAD;
         wr_entry.load_count = WAIT_W'(req_ch.data_byte & SHORT_MASK) + WAIT_W'(1);
      end else begin
         case (req_ch.data_byte)
            CMD_SKIP_BYTE: wr_entry.kind = KIND_SKIP;
            CMD_PSG_WRITE: wr_entry.kind = KIND_PSG;
            CMD_WAIT_WORD: wr_entry.kind = KIND_WAIT_WORD;
            CMD_WAIT_NTSC: begin
               wr_entry.kind       = KIND_WAIT_LOAD;
               wr_entry.load_count = WAIT_NTSC_LOAD;
            end
            CMD_WAIT_PAL: begin
               wr_entry.kind       = KIND_WAIT_LOAD;
               wr_entry.load_count = WAIT_PAL_LOAD;
            end
            CMD_END_DATA: wr_entry.kind = KIND_REWIND;
            default:      wr_entry.kind = KIND_UNKNOWN;
         endcase
      end
   end

endmodule

/* rtl/vpp_queue.sv */
// vpp_queue: short register FIFO between the decoder and the executor.
// Depends on vpp_pkg.
`timescale 1ns / 1ps

module vpp_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_valid,
   input  vpp_pkg::queue_entry_type wr_entry,
   output logic                     wr_ready,
   output logic                     rd_valid,
   output vpp_pkg::queue_entry_type rd_entry,
   input  logic                     rd_take
);
   import vpp_pkg::*;

   queue_entry_type        slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   push, pop;

   // Full / empty flags
   assign wr_ready = !reset && (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_entry = slot_ff[rd_ptr_ff];

   assign push = wr_valid && wr_ready;
   assign pop  = rd_take && rd_valid;

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

/* rtl/vpp_back.sv */
// vpp_back: parser state, wait counter and registered response word.
// Depends on vpp_pkg and vpp_if; reads decoded words from vpp_queue.
`timescale 1ns / 1ps

module vpp_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_valid,
   input  vpp_pkg::queue_entry_type rd_entry,
   output logic                     rd_take,
   vpp_rsp_if.source                rsp_ch
);
   import vpp_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [7:0]        low_ff, low_in;
   logic [WAIT_W-1:0] remaining_ff, remaining_in;
   logic              waiting_ff, waiting_in;
   logic              error_seen_ff, error_seen_in;
   logic              out_valid_ff, out_valid_in;
   rsp_payload_type   out_ff, out_in;
   logic              byte_go;
   logic [WAIT_W-1:0] word_count;
   logic [WAIT_W-1:0] word_load;
   logic [WAIT_W-1:0] dec_count;

   // Take a word when the output register is free or being drained
   assign rd_take = rd_valid && (!out_valid_ff || rsp_ch.ready);
   assign byte_go = rd_take && !rd_entry.is_tick && !waiting_ff;

   assign word_count = {rd_entry.data_byte, low_ff};
   assign word_load  = (word_count == '0) ? '0 : word_count - WAIT_W'(1);
   assign dec_count  = remaining_ff - WAIT_W'(1);

   // Next parser phase
   always_comb begin
      phase_in = phase_ff;
      if (byte_go) begin
         case (phase_ff)
            PH_WAIT_LO: phase_in = PH_WAIT_HI;
            PH_SKIP, PH_PSG, PH_WAIT_HI: phase_in = PH_CMD;
            default: begin
               case (rd_entry.kind)
                  KIND_SKIP:      phase_in = PH_SKIP;
                  KIND_PSG:       phase_in = PH_PSG;
                  KIND_WAIT_WORD: phase_in = PH_WAIT_LO;
                  default:        phase_in = PH_CMD;
               endcase
            end
         endcase
      end
   end

   // Counter, flags and response word
   always_comb begin
      low_in        = low_ff;
      remaining_in  = remaining_ff;
      waiting_in    = waiting_ff;
      error_seen_in = error_seen_ff;
      out_in        = '0;
      if (rd_take && rd_entry.is_tick && waiting_ff) begin
         remaining_in = dec_count;
         waiting_in   = (dec_count != '0);
      end
      if (byte_go) begin
         case (phase_ff)
            PH_SKIP: ;
            PH_PSG: begin
               out_in.psg_write = 1'b1;
               out_in.psg_value = rd_entry.data_byte;
            end
            PH_WAIT_LO: low_in = rd_entry.data_byte;
            PH_WAIT_HI: begin
               remaining_in = word_load;
               waiting_in   = (word_load != '0);
            end
            default: begin
               case (rd_entry.kind)
                  KIND_WAIT_LOAD: begin
                     remaining_in = rd_entry.load_count;
                     waiting_in   = (rd_entry.load_count != '0);
                  end
                  KIND_REWIND:  out_in.rewind = 1'b1;
                  KIND_UNKNOWN: error_seen_in = 1'b1;
                  default: ;
               endcase
            end
         endcase
      end
      out_in.byte_ready      = !waiting_in;
      out_in.unknown_command = error_seen_in;
   end

   assign out_valid_in = rd_take ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_CMD;
         low_ff        <= '0;
         remaining_ff  <= '0;
         waiting_ff    <= 1'b0;
         error_seen_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         low_ff        <= low_in;
         remaining_ff  <= remaining_in;
         waiting_ff    <= waiting_in;
         error_seen_ff <= error_seen_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Response payload, loaded on take
   always_ff @(posedge clock) begin
      if (rd_take) begin
         out_ff <= out_in;
      end
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.psg_write       = out_ff.psg_write;
   assign rsp_ch.psg_value       = out_ff.psg_value;
   assign rsp_ch.byte_ready      = out_ff.byte_ready;
   assign rsp_ch.rewind          = out_ff.rewind;
   assign rsp_ch.unknown_command = out_ff.unknown_command;

`ifndef SYNTH
   // Wait flag tracks a non-zero counter
   a_wait_flag: assert property (@(posedge clock) disable iff (reset)
      waiting_ff == (remaining_ff != '0))
      else $error("wait flag out of step with counter");

   // Error flag is sticky
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      error_seen_ff |=> error_seen_ff)
      else $error("unknown-command flag cleared");

   // A chip write never starts a wait and never coincides with a rewind
   a_write_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.psg_write) |-> (rsp_ch.byte_ready && !rsp_ch.rewind))
      else $error("chip write with wait or rewind");

   // Value is zero unless a write is flagged
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.psg_write) |-> (rsp_ch.psg_value == 8'd0))
      else $error("chip value without write");

   // Bytes are consumed only while no wait is active
   a_no_parse_in_wait: assert property (@(posedge clock) disable iff (reset)
      (rd_take && !rd_entry.is_tick && waiting_ff) |=> $stable(phase_ff))
      else $error("parser moved during a wait");
`endif

endmodule

/* rtl/vgm_psg_command_player_unit.sv */
// vgm_psg_command_player_unit: top level of the sound-log command player.
// Depends on vpp_pkg, vpp_if, vpp_front, vpp_queue and vpp_back.
//
// Usage:
//   req_ch carries one word per handshake: op = 0 offers a stream byte in
//   data_byte, op = 1 reports one elapsed sample tick. rsp_ch returns exactly
//   one word per request word, in order: psg_write/psg_value for chip writes,
//   byte_ready when no wait is active, rewind on the end-of-data command and
//   the sticky unknown_command flag. Bytes offered during a wait are dropped.
//   The decoded word enters the two-entry queue at the accepting edge and
//   is executed from there into the output register, which drives rsp_ch.
//   Throughput is one word per cycle while rsp_ch does not stall; the parser
//   state and the 16-bit wait down counter are updated as each word is taken
//   from the queue.
//   When rsp_ch stalls, the output register holds its word and the queue
//   absorbs up to two more; req_ch.ready then drops until rsp_ch drains.
//   Synchronous reset returns the parser to expecting a command, clears the
//   wait and the error flag, and empties the queue; req_ch.ready is low
//   while reset is high.
`timescale 1ns / 1ps

module vgm_psg_command_player_unit (
   input logic       clock,
   input logic       reset,
   vpp_req_if.sink   req_ch,
   vpp_rsp_if.source rsp_ch
);
   import vpp_pkg::*;

   logic            wr_valid, wr_ready;
   queue_entry_type wr_entry;
   logic            rd_valid, rd_take;
   queue_entry_type rd_entry;

   vpp_front u_front (
      .req_ch   (req_ch),
      .wr_valid (wr_valid),
      .wr_entry (wr_entry),
      .wr_ready (wr_ready)
   );

   vpp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (wr_valid),
      .wr_entry (wr_entry),
      .wr_ready (wr_ready),
      .rd_valid (rd_valid),
      .rd_entry (rd_entry),
      .rd_take  (rd_take)
   );

   vpp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .rd_valid (rd_valid),
      .rd_entry (rd_entry),
      .rd_take  (rd_take),
      .rsp_ch   (rsp_ch)
   );

endmodule
